@@ hdl/ipp_pkg.sv @@
// Shared types and constants for the IP address text parser.
package ipp_pkg;

    localparam logic [7:0]  CHAR_DOT       = 8'h2E;
    localparam logic [7:0]  CHAR_COLON     = 8'h3A;
    localparam logic [7:0]  CHAR_SPACE     = 8'h20;
    localparam logic [7:0]  CHAR_TAB       = 8'h09;
    localparam logic [7:0]  CHAR_CR        = 8'h0D;
    localparam logic [15:0] V4_FIELD_MAX   = 16'd255;
    localparam logic [19:0] V4_FIELD_SAT   = 20'd256;
    localparam logic [2:0]  V6_GROUP_DIGITS = 3'd4;
    localparam logic [2:0]  V4_LAST_FIELD  = 3'd3;
    localparam logic [2:0]  V6_LAST_FIELD  = 3'd7;
    localparam logic [2:0]  DIGIT_CNT_MAX  = 3'd7;

    localparam logic MODE_V4 = 1'b0;
    localparam logic MODE_V6 = 1'b1;

    typedef enum logic [1:0] {
        PH_LEAD = 2'd0,
        PH_BODY = 2'd1,
        PH_PEND = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        ERR_NONE     = 3'd0,
        ERR_EMPTY    = 3'd1,
        ERR_RANGE    = 3'd2,
        ERR_TOO_LONG = 3'd3,
        ERR_NO_SEP   = 3'd4,
        ERR_TRAILING = 3'd5
    } t_err;

    typedef enum logic [1:0] {
        END_SEP   = 2'd0,
        END_OTHER = 2'd1,
        END_EOS   = 2'd2
    } t_end;

    typedef struct packed {
        logic       is_ws;
        logic       is_dec;
        logic       is_hex;
        logic       is_dot;
        logic       is_colon;
        logic [3:0] nib;
    } t_char_cls;

    typedef struct packed {
        t_phase      phase;
        logic [2:0]  fnum;
        logic [15:0] fval;
        logic [2:0]  dcnt;
        t_err        err;
        logic [63:0] upper;
        logic [63:0] lower;
    } t_parse_st;

    typedef struct packed {
        logic        addr_valid;
        t_err        error_kind;
        logic [63:0] addr_upper;
        logic [63:0] addr_lower;
    } t_result;

endpackage

@@ hdl/ipp_char_class.sv @@
// Byte classifier: whitespace, digits, hex nibble value and separators.
module ipp_char_class import ipp_pkg::*; (
    input  logic [7:0] i_char,
    output t_char_cls  o_cls
);

    logic [7:0] w_dec_off;
    logic [7:0] w_lc_off;
    logic [7:0] w_uc_off;
    logic       w_lc;
    logic       w_uc;

    assign w_dec_off = i_char - 8'h30;
    assign w_lc_off  = i_char - 8'h57;
    assign w_uc_off  = i_char - 8'h37;
    assign w_lc      = (i_char >= 8'h61) && (i_char <= 8'h66);
    assign w_uc      = (i_char >= 8'h41) && (i_char <= 8'h46);

    always_comb begin
        o_cls.is_ws    = (i_char == CHAR_SPACE) || ((i_char >= CHAR_TAB) && (i_char <= CHAR_CR));
        o_cls.is_dec   = (i_char >= 8'h30) && (i_char <= 8'h39);
        o_cls.is_hex   = o_cls.is_dec || w_lc || w_uc;
        o_cls.is_dot   = (i_char == CHAR_DOT);
        o_cls.is_colon = (i_char == CHAR_COLON);
        if (w_lc) begin
            o_cls.nib = w_lc_off[3:0];
        end else if (w_uc) begin
            o_cls.nib = w_uc_off[3:0];
        end else begin
            o_cls.nib = w_dec_off[3:0];
        end
    end

endmodule

@@ hdl/ipp_parse_core.sv @@
// Parse state register and the one-byte update of the address scanner.
module ipp_parse_core import ipp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  logic      i_last,
    input  t_char_cls i_cls,
    input  logic      i_mode,
    output t_result   o_res
);

    localparam t_parse_st ST_RESET = '{phase: PH_LEAD, fnum: 3'd0, fval: 16'd0,
                                       dcnt: 3'd0, err: ERR_NONE,
                                       upper: 64'd0, lower: 64'd0};

    t_parse_st r_st;
    t_parse_st n_st;
    t_parse_st w_take;
    t_parse_st w_eos;

    // Close the current field; only called while no error is recorded.
    function automatic t_parse_st finish_field(t_parse_st s, t_end how, logic mode);
        t_parse_st o;
        logic      last_f;
        o = s;
        if (mode == MODE_V4) begin
            last_f = (s.fnum >= V4_LAST_FIELD);
            if (s.dcnt == 3'd0) begin
                o.err = ERR_EMPTY;
            end else if (s.fval > V4_FIELD_MAX) begin
                o.err = ERR_RANGE;
            end else begin
                o.lower = {32'd0, s.lower[23:0], s.fval[7:0]};
            end
        end else begin
            last_f = (s.fnum >= V6_LAST_FIELD);
            if (s.dcnt > V6_GROUP_DIGITS) begin
                o.err = ERR_TOO_LONG;
            end else begin
                o.upper = {s.upper[47:0], s.lower[63:48]};
                o.lower = {s.lower[47:0], s.fval};
            end
        end
        if (o.err == ERR_NONE) begin
            if (last_f) begin
                if (how != END_EOS) begin
                    o.err = ERR_TRAILING;
                end
            end else if (how == END_SEP) begin
                o.fnum = s.fnum + 3'd1;
                o.fval = 16'd0;
                o.dcnt = 3'd0;
            end else begin
                o.err = ERR_NO_SEP;
            end
        end
        return o;
    endfunction

    logic        w_body;
    logic [19:0] w_dec_acc;
    logic [2:0]  w_dcnt_inc;

    assign w_dec_acc  = ({4'd0, r_st.fval} * 20'd10) + {16'd0, i_cls.nib};
    assign w_dcnt_inc = (r_st.dcnt != DIGIT_CNT_MAX) ? r_st.dcnt + 3'd1 : r_st.dcnt;

    always_comb begin
        w_take = r_st;
        w_body = 1'b0;
        if (r_st.err == ERR_NONE) begin
            unique case (r_st.phase)
                PH_LEAD: begin
                    if (!i_cls.is_ws) begin
                        w_take.phase = PH_BODY;
                        w_body       = 1'b1;
                    end
                end
                PH_PEND: begin
                    if (!i_cls.is_ws) begin
                        w_take = finish_field(r_st, END_OTHER, i_mode);
                    end
                end
                PH_BODY: begin
                    if (i_cls.is_ws) begin
                        w_take.phase = PH_PEND;
                    end else begin
                        w_body = 1'b1;
                    end
                end
                default: begin
                    w_take = r_st;
                end
            endcase
            if (w_body) begin
                if (i_mode == MODE_V4) begin
                    if (i_cls.is_dec) begin
                        w_take.fval = (w_dec_acc > V4_FIELD_SAT) ? V4_FIELD_SAT[15:0]
                                                                 : w_dec_acc[15:0];
                        w_take.dcnt = w_dcnt_inc;
                    end else begin
                        w_take = finish_field(w_take, i_cls.is_dot ? END_SEP : END_OTHER,
                                              i_mode);
                    end
                end else begin
                    if (i_cls.is_hex) begin
                        w_take.fval = {r_st.fval[11:0], i_cls.nib};
                        w_take.dcnt = w_dcnt_inc;
                    end else begin
                        w_take = finish_field(w_take, i_cls.is_colon ? END_SEP : END_OTHER,
                                              i_mode);
                    end
                end
            end
        end
    end

    always_comb begin
        if (w_take.err == ERR_NONE) begin
            w_eos = finish_field(w_take, END_EOS, i_mode);
        end else begin
            w_eos = w_take;
        end
        o_res.addr_valid = (w_eos.err == ERR_NONE);
        o_res.error_kind = w_eos.err;
        if (w_eos.err == ERR_NONE) begin
            o_res.addr_upper = (i_mode == MODE_V6) ? w_eos.upper : 64'd0;
            o_res.addr_lower = w_eos.lower;
        end else begin
            o_res.addr_upper = 64'd0;
            o_res.addr_lower = 64'd0;
        end
        n_st = r_st;
        if (i_fire) begin
            n_st = i_last ? ST_RESET : w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_RESET;
        end else begin
            r_st <= n_st;
        end
    end

    a_restart_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_last |=> (r_st.phase == PH_LEAD) && (r_st.err == ERR_NONE)
                             && (r_st.fnum == 3'd0) && (r_st.dcnt == 3'd0))
        else $error("parse state not cleared after final beat");

    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && !i_last && (r_st.err != ERR_NONE) |=> $stable(r_st))
        else $error("parse state changed after an error was recorded");

endmodule

@@ hdl/ip_address_text_parser.sv @@
// Top level of the IP address text parser: input stage, parse core, result stage.
//
// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] char_byte, tlast is_last
// m_axis    out  tdata[63:0] addr_upper, [127:64] addr_lower; tuser[0] addr_valid,
//                tuser[3:1] error_kind; one beat per string, on its final byte
// cfg       in   data[0] addr_mode (0 IPv4, 1 IPv6)
//
// One byte per cycle sustained, but for a final byte held by a waiting result; a string's
// result is valid once its final byte has passed the input register and then the parse update into the result register.
// Synchronous active-low reset clears the mode to IPv4 and the parse state.
// A waiting result stalls only a following final byte; other bytes keep flowing.
module ip_address_text_parser import ipp_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] char_byte
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [127:0] o_m_axis_tdata,   // [63:0] addr_upper, [127:64] addr_lower
    output logic [3:0]   o_m_axis_tuser,   // [0] addr_valid, [3:1] error_kind
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic         i_cfg_data
);

    logic      r_in_valid;
    logic [7:0] r_char;
    logic      r_last;
    logic      r_mode;
    logic      r_out_valid;
    t_result   r_res;
    logic      w_fire;
    t_char_cls w_cls;
    t_result   w_res;

    assign w_fire          = r_in_valid && (!r_last || !r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_fire;
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_char <= i_s_axis_tdata;
            r_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_V4;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_data;
        end
    end

    ipp_char_class u_class (
        .i_char (r_char),
        .o_cls  (w_cls)
    );

    ipp_parse_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_last  (r_last),
        .i_cls   (w_cls),
        .i_mode  (r_mode),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_last) begin
            r_res <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_res.addr_lower, r_res.addr_upper};
    assign o_m_axis_tuser  = {r_res.error_kind, r_res.addr_valid};

    a_input_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_char) && $stable(r_last))
        else $error("input register overwritten before its beat was used");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_fire && r_last))
        else $error("result beat without a final input byte");

    a_valid_vs_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_res.addr_valid == (r_res.error_kind == ERR_NONE)))
        else $error("addr_valid disagrees with error_kind");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_res.addr_valid |-> (r_res.addr_upper == 64'd0)
                                             && (r_res.addr_lower == 64'd0))
        else $error("rejected address carries nonzero data");

endmodule

@@ tb/tb_top.sv @@
// Self-checking stream testbench for the IPv4/IPv6 address text parser.
module tb_top;
    import ipp_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_beat;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata = '0;    // [7:0] char_byte
    logic         i_s_axis_tlast = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [127:0] o_m_axis_tdata;         // [63:0] addr_upper, [127:64] addr_lower
    logic [3:0]   o_m_axis_tuser;         // [0] addr_valid, [3:1] error_kind
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic         i_cfg_data = 1'b0;

    t_beat   text_q[$];
    t_result addr_q[$];
    int      send_idle_pct = 17;
    int      recv_idle_pct = 85;
    int      mismatches = 0;
    logic    hold_trig = 1'b0;
    logic    hold_ack = 1'b0;
    int      hold_left = 0;

    // mirror of the parser state
    logic        addr_mode = MODE_V4;
    t_phase      ph = PH_LEAD;
    logic [2:0]  fnum = '0;
    int unsigned fval = 0;
    logic [2:0]  dcnt = '0;
    t_err        err = ERR_NONE;
    logic [63:0] upper = '0;
    logic [63:0] lower = '0;

    ip_address_text_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    function automatic bit is_space(logic [7:0] c);
        return c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR);
    endfunction

    function automatic void note_err(t_err e);
        if (err == ERR_NONE) err = e;
    endfunction

    function automatic void close_field(t_end how);
        logic fin;
        if (addr_mode == MODE_V4) begin
            fin = fnum >= V4_LAST_FIELD;
            if (dcnt == 0) note_err(ERR_EMPTY);
            else if (fval > V4_FIELD_MAX) note_err(ERR_RANGE);
            else lower = {32'd0, lower[23:0], fval[7:0]};
        end else begin
            fin = fnum >= V6_LAST_FIELD;
            if (dcnt > V6_GROUP_DIGITS) note_err(ERR_TOO_LONG);
            else begin
                upper = {upper[47:0], lower[63:48]};
                lower = {lower[47:0], fval[15:0]};
            end
        end
        if (err != ERR_NONE) return;
        if (fin) begin
            if (how != END_EOS) note_err(ERR_TRAILING);
        end else if (how == END_SEP) begin
            fnum = fnum + 3'd1;
            fval = 0;
            dcnt = '0;
        end else begin
            note_err(ERR_NO_SEP);
        end
    endfunction

    // Advance the mirror by one byte; returns 1 with the address result on a final byte.
    function automatic bit parse_beat(logic [7:0] c, logic eos, output t_result r);
        int unsigned acc;
        int          nib;
        if (err == ERR_NONE) begin
            if (ph == PH_PEND) begin
                // whitespace then more text: the field ends on a foreign byte
                if (!is_space(c)) close_field(END_OTHER);
            end else if (is_space(c)) begin
                if (ph == PH_BODY) ph = PH_PEND;
            end else begin
                ph = PH_BODY;
                if (addr_mode == MODE_V4) begin
                    if (c >= "0" && c <= "9") begin
                        acc = fval * 10 + (c - "0");
                        fval = acc > V4_FIELD_SAT ? V4_FIELD_SAT : acc;
                        if (dcnt < DIGIT_CNT_MAX) dcnt++;
                    end else begin
                        close_field(c == CHAR_DOT ? END_SEP : END_OTHER);
                    end
                end else begin
                    nib = -1;
                    if (c >= "0" && c <= "9") nib = c - "0";
                    else if (c >= "a" && c <= "f") nib = c - "a" + 10;
                    else if (c >= "A" && c <= "F") nib = c - "A" + 10;
                    if (nib >= 0) begin
                        fval = ((fval << 4) | nib) & 32'hFFFF;
                        if (dcnt < DIGIT_CNT_MAX) dcnt++;
                    end else begin
                        close_field(c == CHAR_COLON ? END_SEP : END_OTHER);
                    end
                end
            end
        end
        if (!eos) return 1'b0;
        if (err == ERR_NONE) close_field(END_EOS);
        r.addr_valid = err == ERR_NONE;
        r.error_kind = err;
        r.addr_upper = (err == ERR_NONE && addr_mode == MODE_V6) ? upper : '0;
        r.addr_lower = err == ERR_NONE ? lower : '0;
        ph = PH_LEAD;
        fnum = '0;
        fval = 0;
        dcnt = '0;
        err = ERR_NONE;
        upper = '0;
        lower = '0;
        return 1'b1;
    endfunction

    function automatic void push_beat(logic [7:0] c, logic eos);
        text_q.push_back('{ch: c, last: eos});
    endfunction

    function automatic void push_text(string s, logic eos);
        for (int k = 0; k < s.len(); k++) push_beat(s[k], eos && k == s.len() - 1);
    endfunction

    function automatic logic [7:0] rand_space();
        int k;
        k = $urandom_range(5);
        return k == 5 ? CHAR_SPACE : CHAR_TAB + 8'(k);
    endfunction

    // One random string: mostly well formed, some with a single corruption, some pure noise.
    function automatic int gen_string(logic m);
        logic [7:0] txt[$];
        int         v, n, nd, pick, pos;
        string      num;
        repeat ($urandom_range(2)) txt.push_back(rand_space());
        for (int f = 0; f < (m == MODE_V4 ? 4 : 8); f++) begin
            if (f != 0) txt.push_back(m == MODE_V4 ? CHAR_DOT : CHAR_COLON);
            pick = $urandom_range(79);
            if (m == MODE_V4) begin
                v = pick < 8 ? 0 : pick < 16 ? 255 : $urandom_range(255);
                if (pick == 16) v = $urandom_range(256, 99999);
                if (pick == 17) txt.push_back("0");
                num = $sformatf("%0d", v);
                for (int k = 0; k < num.len(); k++) txt.push_back(num[k]);
            end else begin
                nd = pick == 0 ? 0 : pick == 1 ? 5 : $urandom_range(1, 4);
                v = pick < 8 ? 0 : pick < 16 ? 32'hFFFFF : $urandom;
                for (int d = nd - 1; d >= 0; d--) begin
                    n = (v >> (4 * d)) & 15;
                    txt.push_back(8'(n < 10 ? "0" + n
                                            : ($urandom_range(1) ? "a" : "A") + n - 10));
                end
            end
        end
        repeat ($urandom_range(2)) txt.push_back(rand_space());
        pick = $urandom_range(99);
        if (pick >= 90) begin
            txt.delete();
            repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom_range(255)));
        end else if (pick >= 70) begin
            pos = $urandom_range(txt.size() - 1);
            case ($urandom_range(3))
                0: txt[pos] = 8'($urandom_range(255));
                1: txt.delete(pos);
                2: txt.insert(pos, 8'($urandom_range(255)));
                default: txt.insert(pos, rand_space());
            endcase
        end
        foreach (txt[k]) push_beat(txt[k], k == txt.size() - 1);
        return txt.size();
    endfunction

    task automatic write_mode(logic m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Block is idle once every byte is taken and every result seen, plus pipeline slack.
    task automatic wait_drain();
        while (text_q.size() != 0 || i_s_axis_tvalid || addr_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_cfg_valid && o_cfg_ready) addr_mode <= i_cfg_data;
    end

    // byte driver; the mirror is advanced on each accepted beat
    always @(posedge i_clk) begin
        t_result r;
        bit      took;
        took = i_s_axis_tvalid && o_s_axis_tready;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (took) begin
                if (parse_beat(text_q[0].ch, text_q[0].last, r)) addr_q.push_back(r);
                void'(text_q.pop_front());
            end
            if (!i_s_axis_tvalid || took) begin
                if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= text_q[0].ch;
                    i_s_axis_tlast <= text_q[0].last;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_trig != hold_ack) begin
            hold_ack <= hold_trig;
            hold_left <= 400;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        i_m_axis_tready <= hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (addr_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: tuser=%h tdata=%h",
                             o_m_axis_tuser, o_m_axis_tdata);
            end else begin
                want = addr_q.pop_front();
                if (o_m_axis_tuser[0] !== want.addr_valid
                        || o_m_axis_tuser[3:1] !== want.error_kind
                        || o_m_axis_tdata[63:0] !== want.addr_upper
                        || o_m_axis_tdata[127:64] !== want.addr_lower) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp v=%0b e=%0d u=%h l=%h, got v=%0b e=%0d u=%h l=%h",
                                 want.addr_valid, want.error_kind, want.addr_upper,
                                 want.addr_lower, o_m_axis_tuser[0], o_m_axis_tuser[3:1],
                                 o_m_axis_tdata[63:0], o_m_axis_tdata[127:64]);
                end
            end
        end
    end

    initial begin
        int   sent;
        logic sel;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_mode(MODE_V4);
        push_text("0.0.0.0", 1'b1);
        push_text("255.255.255.255", 1'b1);
        push_text(" \t1.20.3.4\r\n", 1'b1);
        push_text("1..2.3", 1'b1);
        push_text("256.1.1.1", 1'b1);
        push_text("99999.1.1.1", 1'b1);
        push_text("1.2.3", 1'b1);
        push_text("1.2.3.4.5", 1'b1);
        push_text("1.2 3.4", 1'b1);
        push_text("1.2.3.4x", 1'b1);
        push_text("1.2", 1'b0);
        push_beat(8'h00, 1'b0);
        push_text(".3.4", 1'b1);
        push_text("   ", 1'b1);
        // string left open across a mode switch
        push_text("1.2.3.", 1'b0);
        wait_drain();
        write_mode(MODE_V6);
        push_text("4:5:6:7:8", 1'b1);
        push_text("0:0:0:0:0:0:0:0", 1'b1);
        push_text("ffff:FFFF:ffff:FFFF:ffff:FFFF:ffff:FFFF", 1'b1);
        push_text("1:23:456:789a:BcDe:f:0:10", 1'b1);
        push_text(":::::::", 1'b1);
        push_text("12345:0:0:0:0:0:0:0", 1'b1);
        push_text("1:2:3", 1'b1);
        push_text("1:2:3:4:5:6:7:8:9", 1'b1);
        push_text("1:2:3:4:5:6:7:8g", 1'b1);
        push_text("\t", 1'b1);
        push_text("1:2:3:4:5:", 1'b0);
        wait_drain();
        write_mode(MODE_V4);
        push_text("9", 1'b1);

        for (int stage = 0; stage < 3; stage++) begin
            send_idle_pct = stage == 0 ? 17 : stage == 1 ? 85 : 0;
            recv_idle_pct = stage == 0 ? 85 : stage == 1 ? 17 : 0;
            for (int k = 0; k < 2; k++) begin
                sel = k == 0 ? MODE_V6 : MODE_V4;
                wait_drain();
                write_mode(sel);
                if (stage == 2 && k == 0) begin
                    // long receiver stall while bytes keep coming
                    @(posedge i_clk);
                    hold_trig <= ~hold_trig;
                end
                sent = 0;
                while (sent < 70) sent += gen_string(sel);
            end
        end

        wait_drain();
        if (mismatches == 0) $display("tb_top: PASS");
        else $display("tb_top: FAIL");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ ip_address_text_parser.f @@
hdl/ipp_pkg.sv
hdl/ipp_char_class.sv
hdl/ipp_parse_core.sv
hdl/ip_address_text_parser.sv
tb/tb_top.sv
